@@ rtl/core/mnet_pkg.sv @@
// Package for the MIDI note envelope tracker: parser codes, queue entry and
// configuration register indexes. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package mnet_pkg;
  localparam int unsigned LevelOne  = 32768;
  localparam int unsigned FreeBelow = 33;
  localparam logic [19:0] CountMax  = 20'hFFFFF;

  typedef enum logic [1:0] {
    PH_NONE, PH_STATUS, PH_PITCH, PH_VELOCITY
  } phase_e;

  typedef enum logic [1:0] {
    MT_OTHER, MT_ON, MT_OFF
  } msg_e;

  typedef enum logic [1:0] {
    CFG_ATTACK_TICKS = 2'd0,
    CFG_ATTACK_STEP  = 2'd1,
    CFG_DECAY        = 2'd2,
    CFG_RELEASE      = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    CMD_PRESS, CMD_RELEASE, CMD_TICK
  } cmd_e;

  typedef struct packed {
    cmd_e       cmd;
    logic [6:0] pitch;
    logic [6:0] velocity;
  } cmd_t;

  typedef enum logic [2:0] {
    BK_CLEAR, BK_IDLE, BK_READ, BK_UPDATE, BK_FLUSH
  } back_e;
endpackage
`default_nettype wire

@@ rtl/core/mnet_front.sv @@
// Front end: running-status MIDI parser that turns bytes and ticks into
// note commands. Depends on mnet_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mnet_front #(
  parameter int unsigned PITCHES = 128
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire logic           kind_i,
  input  wire logic [7:0]     byte_i,
  output logic                cmd_valid_o,
  input  wire logic           cmd_ready_i,
  output mnet_pkg::cmd_t      cmd_o
);
  import mnet_pkg::*;

  phase_e     phase_q, phase_d;
  msg_e       msg_q, msg_d;
  logic [6:0] pitch_q, pitch_d;
  logic       emit;
  cmd_t       cmd;

  assign in_ready_o = cmd_ready_i;

  always_comb begin
    phase_d = phase_q;
    msg_d   = msg_q;
    pitch_d = pitch_q;
    emit    = 1'b0;
    cmd     = '{cmd: CMD_TICK, pitch: pitch_q, velocity: byte_i[6:0]};
    if (kind_i) begin
      emit = 1'b1;
    end else if (byte_i == 8'd254) begin
    end else if (byte_i[7]) begin
      phase_d = PH_STATUS;
      if (byte_i[7:4] == 4'h9) msg_d = MT_ON;
      else if (byte_i[7:4] == 4'h8) msg_d = MT_OFF;
      else msg_d = MT_OTHER;
    end else if (msg_q != MT_OTHER && phase_q != PH_NONE) begin
      if (phase_q == PH_PITCH) begin
        phase_d = PH_VELOCITY;
        emit = ({25'd0, pitch_q} < PITCHES);
        cmd.cmd = (msg_q == MT_ON && byte_i[6:0] != 7'd0) ? CMD_PRESS : CMD_RELEASE;
      end else begin
        phase_d = PH_PITCH;
        pitch_d = byte_i[6:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_NONE;
      msg_q   <= MT_OTHER;
      pitch_q <= '0;
    end else if (in_valid_i && in_ready_o) begin
      phase_q <= phase_d;
      msg_q   <= msg_d;
      pitch_q <= pitch_d;
    end
  end

  assign cmd_valid_o = in_valid_i && emit;
  assign cmd_o       = cmd;
endmodule
`default_nettype wire

@@ rtl/core/mnet_fifo.sv @@
// Two-entry command queue between parser and envelope engine.
// Depends on mnet_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mnet_fifo (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      wr_valid_i,
  output logic           wr_ready_o,
  input  mnet_pkg::cmd_t wr_data_i,
  output logic           rd_valid_o,
  input  wire logic      rd_ready_i,
  output mnet_pkg::cmd_t rd_data_o
);
  import mnet_pkg::*;

  cmd_t       mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       wr, rd;

  assign wr_ready_o = cnt_q != 2'd2;
  assign rd_valid_o = cnt_q != 2'd0;
  assign rd_data_o  = mem_q[rp_q];
  assign wr = wr_valid_i && wr_ready_o;
  assign rd = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= wr_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= '0;
    end else begin
      if (wr) wp_q <= ~wp_q;
      if (rd) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
    end
  end
endmodule
`default_nettype wire

@@ rtl/core/mnet_back.sv @@
// Envelope engine: note table (valid via nonzero velocity) cleared by a pass
// after reset, per-tick sweep from the highest pitch down. Depends on mnet_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mnet_back #(
  parameter int unsigned PITCHES = 128,
  parameter int unsigned VOICES  = 8
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic [19:0]    attack_ticks_i,
  input  wire logic [15:0]    attack_step_i,
  input  wire logic [15:0]    decay_i,
  input  wire logic [15:0]    release_i,
  input  wire logic           cmd_valid_i,
  output logic                cmd_ready_o,
  input  mnet_pkg::cmd_t      cmd_i,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output logic [6:0]          pitch_o,
  output logic [6:0]          velocity_o,
  output logic [15:0]         level_o,
  output logic                released_o,
  output logic                last_o
);
  import mnet_pkg::*;

  localparam int unsigned PW = $clog2(PITCHES);
  localparam int unsigned VW = $clog2(VOICES + 1);

  logic [6:0]  vel_q [PITCHES];
  logic        rel_q [PITCHES];
  logic [19:0] cnt_q [PITCHES];
  logic [15:0] lvl_q [PITCHES];

  back_e         st_q, st_d;
  logic [PW-1:0] p_q;
  logic [VW-1:0] n_q;
  logic [6:0]    rv_q;
  logic          rr_q;
  logic [19:0]   rc_q;
  logic [15:0]   rl_q;

  // newest report is held back until the next one or the end of the sweep
  logic        hv_q, hrel_q;
  logic [6:0]  hp_q, hvel_q;
  logic [15:0] hl_q;

  // output register
  logic        ov_q, orel_q, olast_q;
  logic [6:0]  op_q, ovel_q;
  logic [15:0] ol_q;

  logic [19:0] nc;
  logic [16:0] asum;
  logic [31:0] prod;
  logic [15:0] nl;
  logic        freed, report, out_free, stall, load_out;

  assign cmd_ready_o = st_q == BK_IDLE;

  always_comb begin
    nc   = rc_q;
    asum = '0;
    nl   = rl_q;
    prod = rl_q * (rr_q ? release_i : decay_i);
    if (!rr_q) begin
      if (rc_q != CountMax) nc = rc_q + 20'd1;
      if (nc <= attack_ticks_i) begin
        asum = {1'b0, rl_q} + {1'b0, attack_step_i};
        nl = (asum > 17'(LevelOne)) ? 16'(LevelOne) : asum[15:0];
      end else begin
        nl = prod[31:16];
      end
    end else begin
      nl = prod[31:16];
    end
    freed  = rr_q && ({16'd0, nl} < FreeBelow);
    report = rv_q != 7'd0 && !freed && n_q < VW'(VOICES);
  end

  assign out_free = !ov_q || out_ready_i;
  // hold the sweep when a new report must push out a held one and the output is full
  assign stall    = report && hv_q && !out_free;
  assign load_out = (st_q == BK_UPDATE && !stall && report && hv_q) ||
                    (st_q == BK_FLUSH && hv_q && out_free);

  always_comb begin
    st_d = st_q;
    case (st_q)
      BK_CLEAR:  if (p_q == '0) st_d = BK_IDLE;
      BK_IDLE:   if (cmd_valid_i && cmd_i.cmd == CMD_TICK) st_d = BK_READ;
      BK_READ:   st_d = BK_UPDATE;
      BK_UPDATE: if (!stall) st_d = (p_q == '0) ? BK_FLUSH : BK_READ;
      BK_FLUSH:  if (!hv_q || out_free) st_d = BK_IDLE;
      default:   st_d = BK_IDLE;
    endcase
  end

  // note table: at most one write or one registered read per cycle
  always_ff @(posedge clk_i) begin
    case (st_q)
      BK_CLEAR: begin
        vel_q[p_q] <= '0; rel_q[p_q] <= 1'b0; cnt_q[p_q] <= '0; lvl_q[p_q] <= '0;
      end
      BK_IDLE: begin
        if (cmd_valid_i) begin
          case (cmd_i.cmd)
            CMD_PRESS: begin
              vel_q[cmd_i.pitch[PW-1:0]] <= cmd_i.velocity;
              rel_q[cmd_i.pitch[PW-1:0]] <= 1'b0;
              cnt_q[cmd_i.pitch[PW-1:0]] <= '0;
              lvl_q[cmd_i.pitch[PW-1:0]] <= '0;
            end
            CMD_RELEASE: rel_q[cmd_i.pitch[PW-1:0]] <= 1'b1;
            default: ;
          endcase
        end
      end
      BK_READ: begin
        rv_q <= vel_q[p_q]; rr_q <= rel_q[p_q];
        rc_q <= cnt_q[p_q]; rl_q <= lvl_q[p_q];
      end
      BK_UPDATE: begin
        if (!stall && rv_q != 7'd0) begin
          if (freed) begin
            vel_q[p_q] <= '0; rel_q[p_q] <= 1'b0;
            cnt_q[p_q] <= '0; lvl_q[p_q] <= '0;
          end else begin
            cnt_q[p_q] <= nc; lvl_q[p_q] <= nl;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= BK_CLEAR;
      p_q     <= PW'(PITCHES - 1);
      n_q     <= '0;
      hv_q    <= 1'b0;
      hp_q    <= '0; hvel_q <= '0; hl_q <= '0; hrel_q <= 1'b0;
      ov_q    <= 1'b0;
      op_q    <= '0; ovel_q <= '0; ol_q <= '0; orel_q <= 1'b0; olast_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (load_out) begin
        ov_q    <= 1'b1;
        op_q    <= hp_q; ovel_q <= hvel_q; ol_q <= hl_q; orel_q <= hrel_q;
        olast_q <= st_q == BK_FLUSH;
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
      case (st_q)
        BK_CLEAR: if (p_q != '0) p_q <= p_q - PW'(1);
        BK_IDLE: begin
          if (cmd_valid_i && cmd_i.cmd == CMD_TICK) begin
            p_q <= PW'(PITCHES - 1);
            n_q <= '0;
          end
        end
        BK_UPDATE: begin
          if (!stall) begin
            if (report) begin
              hv_q <= 1'b1;
              hp_q <= 7'(p_q); hvel_q <= rv_q; hl_q <= nl; hrel_q <= rr_q;
              n_q  <= n_q + VW'(1);
            end
            p_q <= p_q - PW'(1);
          end
        end
        BK_FLUSH: if (hv_q && out_free) hv_q <= 1'b0;
        default: ;
      endcase
    end
  end

  assign out_valid_o = ov_q;
  assign pitch_o     = op_q;
  assign velocity_o  = ovel_q;
  assign level_o     = ol_q;
  assign released_o  = orel_q;
  assign last_o      = olast_q;
endmodule
`default_nettype wire

@@ rtl/core/midi_note_envelope_tracker.sv @@
// MIDI note envelope tracker top level: parser front, command queue, engine.
// A note command enters the queue with its MIDI byte's transaction and reaches the
// note table when the idle engine takes it. A tick is accepted when idle, then each
// entry is read (registered) and updated, then a flush state runs; output stalls hold it.
// Reports trail the sweep by one active note; the last leaves after the sweep.
// Reset clears parser and sets configuration defaults at once, the note table by a pass.
`timescale 1ns / 1ps
`default_nettype none
module midi_note_envelope_tracker #(
  parameter int unsigned PITCHES = 128,
  parameter int unsigned VOICES  = 8
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // midi_byte[7:0]
  input  wire logic        s_axis_tuser,   // kind
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,   // pitch[6:0], velocity[13:7], level[29:14], released[30]
  output logic             m_axis_tlast,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [19:0] cfg_data_i
);
  import mnet_pkg::*;

  logic [19:0] at_q;
  logic [15:0] as_q, df_q, rf_q;
  logic        fv, fr, qv, qr;
  cmd_t        fc, qc;
  logic [6:0]  vp, vv;
  logic [15:0] vl;
  logic        vr;

  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      at_q <= 20'd480; as_q <= 16'd68; df_q <= 16'd65470; rf_q <= 16'd65300;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_ATTACK_TICKS: at_q <= cfg_data_i;
        CFG_ATTACK_STEP:  as_q <= cfg_data_i[15:0];
        CFG_DECAY:        df_q <= cfg_data_i[15:0];
        CFG_RELEASE:      rf_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  mnet_front #(.PITCHES(PITCHES)) u_front (
    .clk_i, .rst_ni, .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .kind_i(s_axis_tuser), .byte_i(s_axis_tdata),
    .cmd_valid_o(fv), .cmd_ready_i(fr), .cmd_o(fc)
  );

  mnet_fifo u_fifo (
    .clk_i, .rst_ni, .wr_valid_i(fv), .wr_ready_o(fr), .wr_data_i(fc),
    .rd_valid_o(qv), .rd_ready_i(qr), .rd_data_o(qc)
  );

  mnet_back #(.PITCHES(PITCHES), .VOICES(VOICES)) u_back (
    .clk_i, .rst_ni, .attack_ticks_i(at_q), .attack_step_i(as_q),
    .decay_i(df_q), .release_i(rf_q),
    .cmd_valid_i(qv), .cmd_ready_o(qr), .cmd_i(qc),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .pitch_o(vp), .velocity_o(vv), .level_o(vl), .released_o(vr),
    .last_o(m_axis_tlast)
  );

  assign m_axis_tdata = {1'b0, vr, vl, vv, vp};
endmodule
`default_nettype wire
